/* rtl/core/emt_pkg.sv */
package emt_pkg;

    // Default widths
    localparam int ANGLE_BITS_DEF    = 21;
    localparam int POSITION_BITS_DEF = 48;

    // Encoder response layout
    localparam int RESP_BYTE_W   = 8;
    localparam int STATUS_W      = 3;
    localparam int PACKED_W      = 24;   // widest angle supported
    localparam int PRESET_W      = 16;
    localparam int STAT_WEAK_BIT   = 2;
    localparam int STAT_STRONG_BIT = 1;

    // Stream field widths
    localparam int CMD_W      = 2;
    localparam int ERR_W      = 2;
    localparam int MAG_W      = 2;
    localparam int S_TUSER_W  = CMD_W + 1;
    localparam int S_TDATA_W  = 3 * RESP_BYTE_W + PRESET_W;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_DIRECTION = 1'b0;   // word index, paddr[2]

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_RESET  = 2'd2
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE        = 2'd0,
        ERR_NOT_STARTED = 2'd1,
        ERR_READ_FAIL   = 2'd2
    } t_err;

    typedef enum logic [MAG_W-1:0] {
        MAG_OK         = 2'd0,
        MAG_TOO_WEAK   = 2'd1,
        MAG_TOO_STRONG = 2'd2
    } t_mag;

endpackage

/* rtl/core/encoder_multiturn_tracker_top.sv */
// Multi-turn tracker for an absolute single-turn encoder. Each transaction on the slave stream
// carries a command (start, sample, reset) and the three response bytes of one angle read with
// its transfer-ok flag; each produces exactly one result transaction holding an error code, the
// saturating signed multi-turn position, the last single-turn angle and the magnet status. An
// accepted transaction is held in the input register, then the angle unpack, the
// half-turn wrap of the difference and the saturating add to the turn count are done in one
// pass into the result register, and a new transaction is taken every cycle while the result
// stream is not stalled. The direction register (address 0) may only be written while the
// block is idle.
module encoder_multiturn_tracker_top #(
    parameter int ANGLE_BITS    = emt_pkg::ANGLE_BITS_DEF,
    parameter int POSITION_BITS = emt_pkg::POSITION_BITS_DEF,
    parameter int M_TDATA_W     = ((POSITION_BITS + ANGLE_BITS + emt_pkg::MAG_W + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: resp_high, resp_mid, resp_low, preset_position
    input  logic [emt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: command, transfer_ok
    input  logic [emt_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    // master stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: position, raw_angle, magnet_status, zero pad
    output logic [M_TDATA_W-1:0]             m_axis_tdata,
    // tuser: error_code
    output logic [emt_pkg::ERR_W-1:0]        m_axis_tuser,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [emt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [emt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [emt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import emt_pkg::*;

    localparam int DW = ANGLE_BITS + 1;                                  // wrapped difference
    localparam int SW = ((POSITION_BITS > DW) ? POSITION_BITS : DW) + 1; // sum before clamp

    localparam logic signed [DW-1:0] HALF  = DW'(1) <<< (ANGLE_BITS - 1);
    localparam logic        [DW-1:0] TURN  = DW'(1) << ANGLE_BITS;
    localparam logic signed [SW-1:0] POS_HI = (SW'(1) <<< (POSITION_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] POS_LO = -POS_HI - SW'(1);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic r_direction;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DIRECTION) ? {{(APB_DATA_W-1){1'b0}}, r_direction}
                                                : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIRECTION) begin
            r_direction <= pwdata[0];
        end
    end

    // ---------------------------------------------------------------
    // Handshake: input register, then result register
    // ---------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic out_free;
    logic fire;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;

    logic [S_TDATA_W-1:0] r_in_data;
    logic [S_TUSER_W-1:0] r_in_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_user <= s_axis_tuser;
        end
    end

    // ---------------------------------------------------------------
    // Unpack
    // ---------------------------------------------------------------
    logic [CMD_W-1:0]      in_cmd;
    logic                  in_ok;
    logic [RESP_BYTE_W-1:0] resp_high, resp_mid, resp_low;
    logic [PRESET_W-1:0]   preset;
    logic [PACKED_W-1:0]   packed_angle;
    logic [PACKED_W-1:0]   preset_wide;
    logic [ANGLE_BITS-1:0] angle;
    logic [ANGLE_BITS-1:0] preset_angle;
    logic [STATUS_W-1:0]   status;

    assign in_cmd    = r_in_user[CMD_W-1:0];
    assign in_ok     = r_in_user[CMD_W];
    assign resp_high = r_in_data[RESP_BYTE_W-1:0];
    assign resp_mid  = r_in_data[2*RESP_BYTE_W-1:RESP_BYTE_W];
    assign resp_low  = r_in_data[3*RESP_BYTE_W-1:2*RESP_BYTE_W];
    assign preset    = r_in_data[S_TDATA_W-1:3*RESP_BYTE_W];

    // top five bits of the low byte are angle bits 4..0
    assign packed_angle = {3'b000, resp_high, resp_mid, resp_low[RESP_BYTE_W-1:STATUS_W]};
    assign preset_wide  = {{(PACKED_W-PRESET_W){1'b0}}, preset};
    assign angle        = packed_angle[ANGLE_BITS-1:0];
    assign preset_angle = preset_wide[ANGLE_BITS-1:0];
    assign status       = resp_low[STATUS_W-1:0];

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic                            r_started, n_started;
    logic                            r_have_first, n_have_first;
    logic [ANGLE_BITS-1:0]           r_last_angle, n_last_angle;
    logic signed [POSITION_BITS-1:0] r_count, n_count;
    logic [STATUS_W-1:0]             r_status, n_status;
    t_err                            err;

    // shortest signed difference, wrapped at half a turn
    logic signed [DW-1:0] diff_raw, diff_wrap, diff_dir;
    logic signed [SW-1:0] count_ext, diff_ext, sum;
    logic signed [POSITION_BITS-1:0] count_track;

    assign diff_raw = $signed({1'b0, angle}) - $signed({1'b0, r_last_angle});

    always_comb begin
        if (diff_raw > HALF) begin
            diff_wrap = diff_raw - $signed(TURN);
        end else if (diff_raw < -HALF) begin
            diff_wrap = diff_raw + $signed(TURN);
        end else begin
            diff_wrap = diff_raw;
        end
    end

    assign diff_dir  = r_direction ? -diff_wrap : diff_wrap;
    assign count_ext = {{(SW-POSITION_BITS){r_count[POSITION_BITS-1]}}, r_count};
    assign diff_ext  = {{(SW-DW){diff_dir[DW-1]}}, diff_dir};
    assign sum       = count_ext + diff_ext;

    // saturate to the position range
    always_comb begin
        if (sum > POS_HI) begin
            count_track = POS_HI[POSITION_BITS-1:0];
        end else if (sum < POS_LO) begin
            count_track = POS_LO[POSITION_BITS-1:0];
        end else begin
            count_track = sum[POSITION_BITS-1:0];
        end
    end

    always_comb begin
        n_started    = r_started;
        n_have_first = r_have_first;
        n_last_angle = r_last_angle;
        n_count      = r_count;
        n_status     = r_status;
        err          = ERR_NONE;
        unique case (in_cmd)
            CMD_START: begin
                n_started = 1'b1;
                if (in_ok) begin
                    n_status     = status;
                    n_last_angle = angle;
                    n_count      = '0;
                    n_have_first = 1'b1;
                end
            end
            CMD_SAMPLE: begin
                if (!r_started) begin
                    err = ERR_NOT_STARTED;
                end else if (!in_ok) begin
                    err = ERR_READ_FAIL;
                end else begin
                    n_status     = status;
                    n_last_angle = angle;
                    n_have_first = 1'b1;
                    n_count      = r_have_first ? count_track : '0;
                end
            end
            CMD_RESET: begin
                if (!r_started) begin
                    err = ERR_NOT_STARTED;
                end else if (preset == '0) begin
                    if (!in_ok) begin
                        err = ERR_READ_FAIL;
                    end else begin
                        n_status     = status;
                        n_last_angle = angle;
                        n_count      = '0;
                        n_have_first = 1'b1;
                    end
                end else begin
                    // nonzero preset overrides the read and its status
                    n_last_angle = preset_angle;
                    n_count      = '0;
                    n_have_first = 1'b1;
                end
            end
            default: begin
                // unused command: report state only
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_have_first <= 1'b0;
            r_last_angle <= '0;
            r_count      <= '0;
            r_status     <= '0;
        end else if (fire) begin
            r_started    <= n_started;
            r_have_first <= n_have_first;
            r_last_angle <= n_last_angle;
            r_count      <= n_count;
            r_status     <= n_status;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    t_mag mag;

    always_comb begin
        priority if (n_status[STAT_WEAK_BIT]) begin
            mag = MAG_TOO_WEAK;
        end else if (n_status[STAT_STRONG_BIT]) begin
            mag = MAG_TOO_STRONG;
        end else begin
            mag = MAG_OK;
        end
    end

    logic [M_TDATA_W-1:0] r_out_data;
    logic [ERR_W-1:0]     r_out_user;

    // zero pad above the status fills tdata to whole bytes
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= M_TDATA_W'({mag, n_last_angle, n_count});
            r_out_user <= err;
        end
    end

    assign m_axis_tdata = r_out_data;
    assign m_axis_tuser = r_out_user;

endmodule
